>>> rtl/core/lpa_pkg.sv
// Package for the LIFO page allocator: status codes and default pool sizes.
// No dependencies; imported by lifo_page_allocator and the testbench.
package lpa_pkg;

  localparam int unsigned DefNumFiles    = 4;
  localparam int unsigned DefPagesPerFile = 16;

  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StNotAlloc = 2'd2
  } status_e;

endpackage

>>> rtl/core/lifo_page_allocator.sv
// LIFO page allocator top level: free stack and allocated list in two RAMs.
// Depends on lpa_pkg (status codes, default pool sizes).
//
// Usage: drive mode_i, file_index_i, page_index_i with start high; the
// command beat is taken at a clock edge where start is high and busy is low.
// mode_i = 0 allocates the page on top of the free stack (the page freed
// last, or the next never-used page in file-major order); mode_i = 1 frees
// the named page. Exactly one result beat follows each command: done_o is
// high for one cycle with status_o, out_file_index_o and out_page_index_o.
// The receiver cannot stall; a result is shown only in that one cycle.
//
// An allocate that takes a never-used page answers in the cycle after the
// command; one that takes a recycled page first reads the free-stack RAM in
// StPop, then answers. A free walks the allocated list one entry per cycle
// through the single read port of the list RAM, searching and closing the
// gap in the same pass, over up to NUM_FILES*PAGES_PER_FILE entries. One
// command at a time.
//
// Reset: all pages free, none allocated. No clearing pass: a watermark marks
// how deep the free stack has ever been popped; pops that reach it hand out
// fresh pages from a counter instead of reading the RAM.
module lifo_page_allocator
  import lpa_pkg::*;
#(
  parameter int unsigned NUM_FILES      = DefNumFiles,
  parameter int unsigned PAGES_PER_FILE = DefPagesPerFile,
  localparam int unsigned FileW = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1,
  localparam int unsigned PageW = (PAGES_PER_FILE > 1) ? $clog2(PAGES_PER_FILE) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic [FileW-1:0]   file_index_i,
  input  logic [PageW-1:0]   page_index_i,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic [FileW-1:0]   out_file_index_o,
  output logic [PageW-1:0]   out_page_index_o
);

  localparam int unsigned TotalPages = NUM_FILES * PAGES_PER_FILE;
  localparam int unsigned AddrW = (TotalPages > 1) ? $clog2(TotalPages) : 1;
  localparam int unsigned CntW  = $clog2(TotalPages + 1);
  localparam int unsigned RefW  = FileW + PageW;

  typedef enum logic [1:0] {
    StIdle,
    StPop,
    StScan
  } state_e;

  // Page reference as stored in both RAMs: {file, page}.
  typedef logic [RefW-1:0] page_ref_t;

  state_e                state_q, state_d;
  logic [CntW-1:0]       free_cnt_q, free_cnt_d;
  logic [CntW-1:0]       alloc_cnt_q, alloc_cnt_d;
  logic [CntW-1:0]       wmark_q, wmark_d;
  logic [FileW-1:0]      fresh_file_q, fresh_file_d;
  logic [PageW-1:0]      fresh_page_q, fresh_page_d;
  page_ref_t             req_q, req_d;
  logic [CntW-1:0]       rd_idx_q, rd_idx_d;
  logic                  rvld_q, rvld_d;
  logic [AddrW-1:0]      ridx_q, ridx_d;
  logic                  found_q, found_d;
  logic                  done_q, done_d;
  status_e               status_q, status_d;
  page_ref_t             out_ref_q, out_ref_d;

  // Free-stack RAM
  page_ref_t             fs_mem [TotalPages];
  page_ref_t             fs_rdata_q;
  logic                  fs_we, fs_re;
  logic [AddrW-1:0]      fs_waddr, fs_raddr;
  page_ref_t             fs_wdata;

  // Allocated-list RAM
  page_ref_t             al_mem [TotalPages];
  page_ref_t             al_rdata_q;
  logic                  al_we, al_re;
  logic [AddrW-1:0]      al_waddr, al_raddr;
  page_ref_t             al_wdata;

  logic                  accept;
  logic                  hit;
  logic                  last_beat;
  logic [CntW-1:0]       free_dec, alloc_dec;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  assign free_dec  = free_cnt_q - CntW'(1);
  assign alloc_dec = alloc_cnt_q - CntW'(1);
  assign hit       = (al_rdata_q == req_q);
  assign last_beat = (CntW'(ridx_q) == alloc_dec);

  always_comb begin
    state_d      = state_q;
    free_cnt_d   = free_cnt_q;
    alloc_cnt_d  = alloc_cnt_q;
    wmark_d      = wmark_q;
    fresh_file_d = fresh_file_q;
    fresh_page_d = fresh_page_q;
    req_d        = req_q;
    rd_idx_d     = rd_idx_q;
    rvld_d       = 1'b0;
    ridx_d       = ridx_q;
    found_d      = found_q;
    done_d       = 1'b0;
    status_d     = status_q;
    out_ref_d    = out_ref_q;

    fs_we    = 1'b0;
    fs_waddr = free_cnt_q[AddrW-1:0];
    fs_wdata = req_q;
    fs_re    = 1'b0;
    fs_raddr = free_dec[AddrW-1:0];
    al_we    = 1'b0;
    al_waddr = alloc_cnt_q[AddrW-1:0];
    al_wdata = fs_rdata_q;
    al_re    = 1'b0;
    al_raddr = rd_idx_q[AddrW-1:0];

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (!mode_i) begin
            if (free_cnt_q == '0) begin
              done_d    = 1'b1;
              status_d  = StEmpty;
              out_ref_d = '0;
            end else if (free_cnt_q == wmark_q) begin
              // Top of stack never written: hand out the next fresh page.
              al_we       = 1'b1;
              al_wdata    = {fresh_file_q, fresh_page_q};
              done_d      = 1'b1;
              status_d    = StOk;
              out_ref_d   = {fresh_file_q, fresh_page_q};
              free_cnt_d  = free_dec;
              alloc_cnt_d = alloc_cnt_q + CntW'(1);
              wmark_d     = wmark_q - CntW'(1);
              if (fresh_page_q == PageW'(PAGES_PER_FILE - 1)) begin
                fresh_page_d = '0;
                fresh_file_d = fresh_file_q + FileW'(1);
              end else begin
                fresh_page_d = fresh_page_q + PageW'(1);
              end
            end else begin
              fs_re   = 1'b1;
              state_d = StPop;
            end
          end else begin
            req_d = {file_index_i, page_index_i};
            if (alloc_cnt_q == '0) begin
              done_d    = 1'b1;
              status_d  = StNotAlloc;
              out_ref_d = {file_index_i, page_index_i};
            end else begin
              // Start the walk at entry 0.
              al_re    = 1'b1;
              al_raddr = '0;
              rvld_d   = 1'b1;
              ridx_d   = '0;
              rd_idx_d = CntW'(1);
              found_d  = 1'b0;
              state_d  = StScan;
            end
          end
        end
      end

      StPop: begin
        al_we       = 1'b1;
        al_wdata    = fs_rdata_q;
        done_d      = 1'b1;
        status_d    = StOk;
        out_ref_d   = fs_rdata_q;
        free_cnt_d  = free_dec;
        alloc_cnt_d = alloc_cnt_q + CntW'(1);
        state_d     = StIdle;
      end

      StScan: begin
        // Keep one read in flight ahead of the compare.
        if (rd_idx_q < alloc_cnt_q) begin
          al_re    = 1'b1;
          rvld_d   = 1'b1;
          ridx_d   = rd_idx_q[AddrW-1:0];
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (rvld_q) begin
          // Entries past the hit move down by one.
          if (found_q) begin
            al_we    = 1'b1;
            al_waddr = ridx_q - AddrW'(1);
            al_wdata = al_rdata_q;
          end
          found_d = found_q || hit;
          if (last_beat) begin
            done_d    = 1'b1;
            out_ref_d = req_q;
            state_d   = StIdle;
            if (found_q || hit) begin
              status_d    = StOk;
              alloc_cnt_d = alloc_dec;
              free_cnt_d  = free_cnt_q + CntW'(1);
              fs_we       = 1'b1;
              fs_wdata    = req_q;
            end else begin
              status_d = StNotAlloc;
            end
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      free_cnt_q   <= CntW'(TotalPages);
      alloc_cnt_q  <= '0;
      wmark_q      <= CntW'(TotalPages);
      fresh_file_q <= '0;
      fresh_page_q <= '0;
      rd_idx_q     <= '0;
      rvld_q       <= 1'b0;
      found_q      <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_cnt_q   <= free_cnt_d;
      alloc_cnt_q  <= alloc_cnt_d;
      wmark_q      <= wmark_d;
      fresh_file_q <= fresh_file_d;
      fresh_page_q <= fresh_page_d;
      rd_idx_q     <= rd_idx_d;
      rvld_q       <= rvld_d;
      found_q      <= found_d;
      done_q       <= done_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    ridx_q    <= ridx_d;
    status_q  <= status_d;
    out_ref_q <= out_ref_d;
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    if (fs_re) begin
      fs_rdata_q <= fs_mem[fs_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (al_we) begin
      al_mem[al_waddr] <= al_wdata;
    end
    if (al_re) begin
      al_rdata_q <= al_mem[al_raddr];
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign out_file_index_o = out_ref_q[RefW-1:PageW];
  assign out_page_index_o = out_ref_q[PageW-1:0];

  // Every page is either free or allocated.
  a_pool_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW+1)'(free_cnt_q) + (CntW+1)'(alloc_cnt_q) == (CntW+1)'(TotalPages))
    else $error("free and allocated counts do not cover the pool");

  // Fresh-page watermark never rises above the stack depth.
  a_wmark_below_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wmark_q <= free_cnt_q)
    else $error("watermark above free count");

  // A list walk only runs over a non-empty list.
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (alloc_cnt_q != '0))
    else $error("walk over an empty allocated list");

  // Out of pages only when the free stack is really empty.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StEmpty) |-> (free_cnt_q == '0))
    else $error("empty reported with free pages left");

  // An allocate through the free-stack RAM grows the allocated list by one.
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPop) |=> (alloc_cnt_q == $past(alloc_cnt_q) + CntW'(1)))
    else $error("pop did not grow the allocated list");

endmodule

>>> tb/tb.sv
// Self-checking testbench for lifo_page_allocator: directed and random command beats.
// Depends on lpa_pkg (status codes, default pool sizes) and the lifo_page_allocator RTL.
`timescale 1ns / 1ps

module tb;
  import lpa_pkg::*;

  localparam int unsigned NumFiles     = DefNumFiles;
  localparam int unsigned PagesPerFile = DefPagesPerFile;
  localparam int unsigned NumPages     = NumFiles * PagesPerFile;
  localparam int unsigned FileW        = (NumFiles > 1) ? $clog2(NumFiles) : 1;
  localparam int unsigned PageW        = (PagesPerFile > 1) ? $clog2(PagesPerFile) : 1;

  localparam int DirItems   = 16;
  localparam int RandItems  = 2000;
  localparam int TotalItems = DirItems + RandItems;
  // Worst case per beat: a full list walk, the longest sender gap, margin on top.
  localparam int CycleLimit = TotalItems * (NumPages + 1 + 40) * 4;

  typedef struct packed {
    logic             mode;
    logic [FileW-1:0] file;
    logic [PageW-1:0] page;
  } page_cmd_t;

  typedef struct packed {
    logic [FileW-1:0] file;
    logic [PageW-1:0] page;
  } page_ref_t;

  typedef struct {
    status_e          status;
    logic [FileW-1:0] file;
    logic [PageW-1:0] page;
  } page_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               mode_i = 1'b0;
  logic [FileW-1:0]   file_index_i = '0;
  logic [PageW-1:0]   page_index_i = '0;
  logic               done_o;
  logic [StatusW-1:0] status_o;
  logic [FileW-1:0]   out_file_index_o;
  logic [PageW-1:0]   out_page_index_o;

  // Predicted pool: free stack (top at free_cnt-1) and compacted allocated list.
  page_ref_t free_pages [NumPages];
  int        free_cnt;
  page_ref_t alloc_pages [NumPages];
  int        alloc_cnt;

  page_cmd_t page_cmd_q [$];     // command beats waiting for the driver
  page_res_t page_result_q [$];  // predicted result beats, oldest first
  page_cmd_t cur_cmd;            // beat currently presented on the inputs
  page_res_t want;
  int        cmds_taken = 0;
  int        cmds_queued = 0;
  int        err_cnt = 0;
  int        cycle_cnt = 0;

  lifo_page_allocator #(
    .NUM_FILES      (NumFiles),
    .PAGES_PER_FILE (PagesPerFile)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .file_index_i     (file_index_i),
    .page_index_i     (page_index_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .out_file_index_o (out_file_index_o),
    .out_page_index_o (out_page_index_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one accepted command to the predicted pool and return its result beat.
  function automatic page_res_t next_page_result(input page_cmd_t c);
    page_res_t r;
    page_ref_t p;
    bit        hit;
    int        pos;
    hit = 1'b0;
    pos = 0;
    p.file = c.file;
    p.page = c.page;
    if (!c.mode) begin
      if (free_cnt == 0 || alloc_cnt >= NumPages) begin
        // Pool exhausted: report empty, zero the page fields, touch nothing.
        r.status = StEmpty;
        r.file   = '0;
        r.page   = '0;
      end else begin
        free_cnt--;
        p = free_pages[free_cnt];
        alloc_pages[alloc_cnt] = p;
        alloc_cnt++;
        r.status = StOk;
        r.file   = p.file;
        r.page   = p.page;
      end
    end else begin
      for (int k = 0; k < alloc_cnt; k++) begin
        if (!hit && alloc_pages[k] == p) begin
          hit = 1'b1;
          pos = k;
        end
      end
      r.file = c.file;
      r.page = c.page;
      if (!hit || free_cnt >= NumPages) begin
        // Page not on the allocated list: echo the request, leave the pool alone.
        r.status = StNotAlloc;
      end else begin
        // Close the gap, then push the page on top of the free stack.
        for (int k = pos; k + 1 < alloc_cnt; k++) alloc_pages[k] = alloc_pages[k + 1];
        alloc_cnt--;
        alloc_pages[alloc_cnt] = '0;
        free_pages[free_cnt] = p;
        free_cnt++;
        r.status = StOk;
      end
    end
    return r;
  endfunction

  function automatic void push_cmd(input logic mode, input int file, input int page);
    page_cmd_t c;
    c.mode = mode;
    c.file = file[FileW-1:0];
    c.page = page[PageW-1:0];
    page_cmd_q.push_back(c);
    cmds_queued++;
  endfunction

  // Driver: hold the beat while busy, then take the next pending one or idle.
  // Sender idle rate per cycle: 18% in the first third, 49% in the second, none after.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // Beat accepted at this edge: predict its result before moving on.
        page_result_q.push_back(next_page_result(cur_cmd));
        cmds_taken++;
      end
      if (!start || !busy) begin
        if (page_cmd_q.size() != 0 &&
            $urandom_range(99) >= ((cmds_taken < TotalItems / 3)     ? 18 :
                                   (cmds_taken < 2 * TotalItems / 3) ? 49 : 0)) begin
          cur_cmd      = page_cmd_q.pop_front();
          start        <= 1'b1;
          mode_i       <= cur_cmd.mode;
          file_index_i <= cur_cmd.file;
          page_index_i <= cur_cmd.page;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done_o cycle is a result beat; match it to the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("Some tests failed");
        $finish;
      end
      if (done_o) begin
        if (page_result_q.size() == 0) begin
          $display("%0t: unexpected result beat: status %0d file %0d page %0d",
                   $time, status_o, out_file_index_o, out_page_index_o);
          err_cnt++;
        end else begin
          want = page_result_q.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status_o);
            err_cnt++;
          end
          if (out_file_index_o !== want.file) begin
            $display("%0t: file index mismatch: expected %0d, actual %0d",
                     $time, want.file, out_file_index_o);
            err_cnt++;
          end
          if (out_page_index_o !== want.page) begin
            $display("%0t: page index mismatch: expected %0d, actual %0d",
                     $time, want.page, out_page_index_o);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int        alloc_pct;
    int        pick;
    page_ref_t p;

    // Pool after reset: every page free, file-major, first page on top.
    for (int n = 0; n < NumPages; n++) begin
      free_pages[n].file = FileW'((NumPages - 1 - n) / PagesPerFile);
      free_pages[n].page = PageW'((NumPages - 1 - n) % PagesPerFile);
      alloc_pages[n]     = '0;
    end
    free_cnt  = NumPages;
    alloc_cnt = 0;

    // Directed beats. Allocate ignores the page fields, so drive them at the extremes.
    push_cmd(1'b0, NumFiles - 1, PagesPerFile - 1);  // fresh page 0/0
    push_cmd(1'b0, 0, 0);                             // fresh page 0/1
    push_cmd(1'b0, 1, 5);                             // fresh page 0/2
    push_cmd(1'b1, 0, 1);                             // free from the middle of the list
    push_cmd(1'b1, 0, 1);                             // same page again: not allocated
    push_cmd(1'b0, 2, 9);                             // recycled page from the stack
    push_cmd(1'b1, NumFiles - 1, PagesPerFile - 1);   // never allocated, top indexes
    push_cmd(1'b1, 0, 0);                             // free the head of the list
    push_cmd(1'b1, 0, 1);                             // free the tail of the list
    push_cmd(1'b1, 0, 2);                             // free the last entry
    push_cmd(1'b1, 0, 2);                             // free with an empty list
    push_cmd(1'b0, 0, 0);                             // last freed comes out first
    push_cmd(1'b0, 0, 0);
    push_cmd(1'b0, 0, 0);
    push_cmd(1'b0, 3, 3);                             // stack drained to the watermark: fresh page
    push_cmd(1'b1, 0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random beats, generated a little ahead of the driver from the predicted pool.
    // The allocate share moves every 100 beats so the pool fills up, runs dry and drains.
    alloc_pct = 50;
    for (int i = 0; i < RandItems; i++) begin
      while (page_cmd_q.size() >= 2) @(posedge clk_i);
      if (i % 100 == 0) begin
        case ($urandom_range(3))
          0: begin
            alloc_pct = 15;
          end
          1: begin
            alloc_pct = 50;
          end
          2: begin
            alloc_pct = 85;
          end
          default: begin
            alloc_pct = 97;
          end
        endcase
      end
      if ($urandom_range(99) < alloc_pct) begin
        push_cmd(1'b0, $urandom_range(NumFiles - 1), $urandom_range(PagesPerFile - 1));
      end else if ($urandom_range(99) < 80 && alloc_cnt > 0) begin
        // Free a page that is on the list: head, tail or anywhere between.
        case ($urandom_range(3))
          0: begin
            pick = 0;
          end
          1: begin
            pick = alloc_cnt - 1;
          end
          default: begin
            pick = $urandom_range(alloc_cnt - 1);
          end
        endcase
        p = alloc_pages[pick];
        push_cmd(1'b1, p.file, p.page);
      end else begin
        // Noise: free any page, allocated or not.
        push_cmd(1'b1, $urandom_range(NumFiles - 1), $urandom_range(PagesPerFile - 1));
      end
    end

    // Drain: every beat taken, every result in, then let the block settle.
    while (cmds_taken != cmds_queued || page_result_q.size() != 0) @(posedge clk_i);
    repeat (NumPages + 8) @(posedge clk_i);
    if (err_cnt == 0 && page_result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lpa_pkg.sv
rtl/core/lifo_page_allocator.sv
tb/tb.sv
